/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of this block.
// Both macros expect a signal named clk in the enclosing scope; BOLE_ASSERT also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define BOLE_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bounded ordered list engine: assertion failed");

// Checked at every clock edge, reset included.
`define BOLE_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("bounded ordered list engine: assertion failed");

`endif

/* rtl/core/bole_pkg.sv */
`default_nettype none

package bole_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT   = 4'd0,
        CMD_PUSH_BACK    = 4'd1,
        CMD_PEEK_FIRST   = 4'd2,
        CMD_PEEK_LAST    = 4'd3,
        CMD_PEEK_INDEX   = 4'd4,
        CMD_REMOVE_FIRST = 4'd5,
        CMD_REMOVE_LAST  = 4'd6,
        CMD_REMOVE_INDEX = 4'd7,
        CMD_REMOVE_VALUE = 4'd8,
        CMD_CONTAINS     = 4'd9,
        CMD_CLEAR        = 4'd10
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_EMPTY   = 2'd1,
        STS_FULL    = 2'd2,
        STS_MISSING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_TAKE,
        ST_SCAN,
        ST_SHIFT_DN,
        ST_SHIFT_UP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     present;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/bounded_ordered_list_engine.sv */
// Ordered list of up to CAPACITY signed 32-bit elements, front at index 0.
// Commands arrive as words on the s_axis channel; every command gives exactly
// one result word on the m_axis channel, in command order.
// The elements live in a one-read, one-write memory with a registered read,
// so elements are searched and moved one at a time.
// Push back, clear, rejected commands and unused codes need no memory pass;
// peeks read one element, push front shifts every element up by one,
// removes shift the elements behind the removed one down, and contains
// and remove value scan from the front until a match or the end.
// One command is in the engine at a time; the next one is taken as soon as
// the previous result has moved to the output register.
// Reset empties the list; memory contents are not cleared, since only entries
// below the current length are ever read.
// When the receiver stalls, the result word waits in the output register and
// the engine finishes at most one more command, which then holds until the
// output register drains.
`default_nettype none

`include "assert_macros.svh"

module bounded_ordered_list_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command [3:0], value [35:4], position [43:36], zero [47:44]
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // result_data [31:0], present [32], status [34:33], element_count [39:35]
    output logic [39:0]      m_axis_tdata
);

    import bole_pkg::*;

    logic   res_valid;
    logic   res_ready;
    res_t   res;
    res_t   out_reg;
    logic   out_valid_reg, out_valid_next;
    logic   load;
    logic   out_full;
    logic   out_empty;
    logic   out_blank;

    bole_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .command   (cmd_e_t'(s_axis_tdata[3:0])),
        .value     ($signed(s_axis_tdata[35:4])),
        .position  (s_axis_tdata[43:36]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign load           = res_valid && res_ready;
    assign out_valid_next = load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid        = out_valid_reg;
    assign m_axis_tdata[31:0]   = out_reg.data;
    assign m_axis_tdata[32]     = out_reg.present;
    assign m_axis_tdata[34:33]  = out_reg.status;
    assign m_axis_tdata[39:35]  = COUNT_W'(out_reg.count);

    assign out_full  = m_axis_tvalid && (out_reg.status == STS_FULL);
    assign out_empty = m_axis_tvalid && (out_reg.status == STS_EMPTY);
    assign out_blank = (out_reg.count == '0) && (out_reg.data == '0) && !out_reg.present;

    `BOLE_ASSERT(a_one_command_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    `BOLE_ASSERT_ALWAYS(a_count_bound, m_axis_tvalid |-> out_reg.count <= CNT_W'(CAPACITY))
    `BOLE_ASSERT(a_full_means_capacity, out_full |-> out_reg.count == CNT_W'(CAPACITY))
    `BOLE_ASSERT(a_empty_gives_nothing, out_empty |-> out_blank)

endmodule

`default_nettype wire

/* rtl/core/bole_ram.sv */
`default_nettype none

module bole_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bole_ctrl.sv */
`default_nettype none

module bole_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire bole_pkg::cmd_e_t                command,
    input  wire logic signed [bole_pkg::DATA_W-1:0] value,
    input  wire logic [bole_pkg::POS_W-1:0]      position,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output bole_pkg::res_t                       res
);

    import bole_pkg::*;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     present_reg, present_next;
    status_t                  status_reg, status_next;
    cmd_e_t                   cmd_reg;
    logic signed [DATA_W-1:0] val_reg;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]        mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [DATA_W-1:0]        mem_rdata;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     pos_miss;
    logic [CNT_W-1:0]         pos_ptr;
    logic [CNT_W-1:0]         len_inc;
    logic [CNT_W-1:0]         len_m1;
    logic [CNT_W-1:0]         ptr_inc;
    logic [CNT_W-1:0]         ptr_inc2;
    logic [CNT_W-1:0]         ptr_m1;
    logic [CNT_W-1:0]         ptr_m2;
    logic                     more_after;
    logic                     shift_more;
    logic                     match;

    // Reads always run ahead of the writes of a shift, so no entry is read and
    // written in the same cycle and no forwarding path is needed.
    bole_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign full       = (len_reg == CNT_W'(CAPACITY));
    assign empty      = (len_reg == '0);
    assign pos_miss   = (CMP_W'(position) >= CMP_W'(len_reg));
    assign pos_ptr    = CNT_W'(CMP_W'(position));
    assign len_inc    = len_reg + CNT_W'(1);
    assign len_m1     = len_reg - CNT_W'(1);
    assign ptr_inc    = ptr_reg + CNT_W'(1);
    assign ptr_inc2   = ptr_reg + CNT_W'(2);
    assign ptr_m1     = ptr_reg - CNT_W'(1);
    assign ptr_m2     = ptr_reg - CNT_W'(2);
    assign more_after = (ptr_inc < len_reg);
    assign shift_more = (ptr_inc2 < len_reg);
    assign match      = (mem_rdata == DATA_W'(val_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_PUSH_FRONT:
                            state_next = full ? ST_DONE : ST_SHIFT_UP;
                        CMD_PEEK_FIRST, CMD_PEEK_LAST:
                            state_next = empty ? ST_DONE : ST_PEEK;
                        CMD_PEEK_INDEX:
                            state_next = (empty || pos_miss) ? ST_DONE : ST_PEEK;
                        CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
                            state_next = empty ? ST_DONE : ST_TAKE;
                        CMD_REMOVE_INDEX:
                            state_next = (empty || pos_miss) ? ST_DONE : ST_TAKE;
                        CMD_REMOVE_VALUE, CMD_CONTAINS:
                            state_next = empty ? ST_DONE : ST_SCAN;
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_PEEK:
                state_next = ST_DONE;
            ST_TAKE:
                state_next = more_after ? ST_SHIFT_DN : ST_DONE;
            ST_SCAN:
            begin
                if (match)
                begin
                    if (cmd_reg == CMD_CONTAINS || !more_after)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_DN;
                    end
                end
                else if (!more_after)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_DN:
                state_next = shift_more ? ST_SHIFT_DN : ST_DONE;
            ST_SHIFT_UP:
                state_next = (ptr_reg == '0) ? ST_DONE : ST_SHIFT_UP;
            ST_DONE:
                state_next = res_ready ? ST_IDLE : ST_DONE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        len_next     = len_reg;
        ptr_next     = ptr_reg;
        data_next    = data_reg;
        present_next = present_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg[ADDR_W-1:0];
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next    = '0;
                    present_next = 1'b0;
                    status_next  = STS_OK;
                    case (command)
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                ptr_next  = len_reg;
                                mem_re    = !empty;
                                mem_raddr = len_m1[ADDR_W-1:0];
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = len_reg[ADDR_W-1:0];
                                mem_wdata = DATA_W'(value);
                                len_next  = len_inc;
                            end
                        end
                        CMD_PEEK_FIRST, CMD_REMOVE_FIRST, CMD_REMOVE_VALUE, CMD_CONTAINS:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                ptr_next  = '0;
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end
                        end
                        CMD_PEEK_LAST, CMD_REMOVE_LAST:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                ptr_next  = len_m1;
                                mem_re    = 1'b1;
                                mem_raddr = len_m1[ADDR_W-1:0];
                            end
                        end
                        CMD_PEEK_INDEX, CMD_REMOVE_INDEX:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (pos_miss)
                            begin
                                status_next = STS_MISSING;
                            end
                            else
                            begin
                                ptr_next  = pos_ptr;
                                mem_re    = 1'b1;
                                mem_raddr = pos_ptr[ADDR_W-1:0];
                            end
                        end
                        CMD_CLEAR:
                            len_next = '0;
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PEEK:
                data_next = $signed(mem_rdata);
            ST_TAKE:
            begin
                data_next = $signed(mem_rdata);
                if (more_after)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[ADDR_W-1:0];
                end
                else
                begin
                    len_next = len_m1;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    present_next = 1'b1;
                    data_next    = $signed(mem_rdata);
                    if (cmd_reg != CMD_CONTAINS)
                    begin
                        if (more_after)
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = ptr_inc[ADDR_W-1:0];
                        end
                        else
                        begin
                            len_next = len_m1;
                        end
                    end
                end
                else if (more_after)
                begin
                    ptr_next  = ptr_inc;
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[ADDR_W-1:0];
                end
                else
                begin
                    status_next = STS_MISSING;
                end
            end
            ST_SHIFT_DN:
            begin
                mem_we = 1'b1;
                if (shift_more)
                begin
                    ptr_next  = ptr_inc;
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc2[ADDR_W-1:0];
                end
                else
                begin
                    len_next = len_m1;
                end
            end
            ST_SHIFT_UP:
            begin
                mem_we = 1'b1;
                if (ptr_reg == '0)
                begin
                    mem_wdata = DATA_W'(val_reg);
                    len_next  = len_inc;
                end
                else
                begin
                    ptr_next  = ptr_m1;
                    mem_re    = (ptr_reg > CNT_W'(1));
                    mem_raddr = ptr_m2[ADDR_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        data_reg    <= data_next;
        present_reg <= present_next;
        status_reg  <= status_next;
        if (accept)
        begin
            cmd_reg <= command;
            val_reg <= value;
        end
    end

    assign res_valid   = (state_reg == ST_DONE);
    assign res.data    = data_reg;
    assign res.present = present_reg;
    assign res.status  = status_reg;
    assign res.count   = len_reg;

endmodule

`default_nettype wire
